### rtl/rsu_pkg.sv
// Shared types and constants for the reservation station unit.
// No dependencies; the top level and the entry array refer to this package by scoped names.

package rsu_pkg;

    localparam int OPC_W   = 4;
    localparam int ROB_W   = 5;
    localparam int TAG_W   = 5;
    localparam int VAL_W   = 32;
    localparam int REL_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 5;
    localparam int MASK_W  = 8;
    localparam int LAT_W   = 8;

    localparam logic [LAT_W-1:0] LAT_RESET = 8'd1;

    typedef enum logic [1:0] {
        CMD_ISSUE   = 2'd0,
        CMD_BCAST   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_FLUSH   = 2'd3
    } cmd_t;

    // One command word as held in the input register
    typedef struct packed {
        cmd_t               command;
        logic [OPC_W-1:0]   opcode;
        logic [ROB_W-1:0]   rob_id;
        logic               src1_waiting;
        logic [TAG_W-1:0]   src1_tag;
        logic [VAL_W-1:0]   src1_value;
        logic               src2_waiting;
        logic [TAG_W-1:0]   src2_tag;
        logic [VAL_W-1:0]   src2_value;
        logic [TAG_W-1:0]   bcast_tag;
        logic [VAL_W-1:0]   bcast_value;
        logic [REL_W-1:0]   release_slot;
    } op_t;

endpackage

### rtl/reservation_station_unit.sv
// Top level of the reservation station: input register, entry array, result register.
// Depends on rsu_pkg, rsu_slot_pick and rsu_entry_array.
//
//   channel   handshake                  payload
//   --------  -------------------------  --------------------------------------------
//   command   start & !busy              command, opcode, rob_id, src1_*, src2_*,
//                                        bcast_tag, bcast_value, release_slot
//   config    cfg_valid & cfg_ready      cfg_data (exec_latency)
//   result    done (one-cycle strobe)    accepted, slot, full_res, captured_count,
//                                        ready_mask
//
// A command word is registered at the accepting edge; the entry array and the result
// register load together at the next edge, and done rises at that edge too, so a new word
// can follow every cycle (busy stays low). The next word sees the state the previous one
// left, since the entry flags load at that same edge.
// Reset clears all entries and sets exec_latency to 1; payload stores stay unset.
// The result port cannot be stalled; cfg_ready drops while a word is in flight.

module reservation_station_unit #(
    parameter int RS_DEPTH = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [rsu_pkg::OPC_W-1:0]       opcode,
    input  logic [rsu_pkg::ROB_W-1:0]       rob_id,
    input  logic                            src1_waiting,
    input  logic [rsu_pkg::TAG_W-1:0]       src1_tag,
    input  logic [rsu_pkg::VAL_W-1:0]       src1_value,
    input  logic                            src2_waiting,
    input  logic [rsu_pkg::TAG_W-1:0]       src2_tag,
    input  logic [rsu_pkg::VAL_W-1:0]       src2_value,
    input  logic [rsu_pkg::TAG_W-1:0]       bcast_tag,
    input  logic [rsu_pkg::VAL_W-1:0]       bcast_value,
    input  logic [rsu_pkg::REL_W-1:0]       release_slot,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rsu_pkg::LAT_W-1:0]       cfg_data,
    output logic                            done,
    output logic                            accepted,
    output logic [rsu_pkg::SLOT_W-1:0]      slot,
    output logic                            full_res,
    output logic [rsu_pkg::CNT_W-1:0]       captured_count,
    output logic [rsu_pkg::MASK_W-1:0]      ready_mask
);

    localparam int IDX_W  = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
    localparam int CAP_W  = $clog2(2 * RS_DEPTH + 1);
    localparam int PAD_W  = (RS_DEPTH > rsu_pkg::MASK_W) ? RS_DEPTH : rsu_pkg::MASK_W;

    logic                        op_valid_reg;
    rsu_pkg::op_t                op_reg;
    logic [rsu_pkg::LAT_W-1:0]   latency_reg;

    logic [RS_DEPTH-1:0]         busy_vec;
    logic [RS_DEPTH-1:0]         ready_next;
    logic [CAP_W-1:0]            captured;
    logic                        pick_found;
    logic [IDX_W-1:0]            pick_idx;

    logic                        done_reg;
    logic                        accepted_reg, accepted_next;
    logic [rsu_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic                        full_reg, full_next;
    logic [rsu_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [rsu_pkg::MASK_W-1:0]  mask_reg;

    logic [31:0]                 idx_ext;
    logic [31:0]                 cap_ext;
    logic [PAD_W-1:0]            ready_pad;

    assign busy      = 1'b0;
    assign cfg_ready = !op_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            latency_reg <= rsu_pkg::LAT_RESET;
        else if (cfg_valid && cfg_ready)
            latency_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_valid_reg <= 1'b0;
        else
            op_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg.command      <= rsu_pkg::cmd_t'(command);
            op_reg.opcode       <= opcode;
            op_reg.rob_id       <= rob_id;
            op_reg.src1_waiting <= src1_waiting;
            op_reg.src1_tag     <= src1_tag;
            op_reg.src1_value   <= src1_value;
            op_reg.src2_waiting <= src2_waiting;
            op_reg.src2_tag     <= src2_tag;
            op_reg.src2_value   <= src2_value;
            op_reg.bcast_tag    <= bcast_tag;
            op_reg.bcast_value  <= bcast_value;
            op_reg.release_slot <= release_slot;
        end
    end

    rsu_slot_pick #(
        .RS_DEPTH (RS_DEPTH),
        .IDX_W    (IDX_W)
    ) u_pick (
        .busy_vec (busy_vec),
        .found    (pick_found),
        .idx      (pick_idx)
    );

    rsu_entry_array #(
        .RS_DEPTH (RS_DEPTH),
        .IDX_W    (IDX_W),
        .CAP_W    (CAP_W)
    ) u_entries (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid_reg),
        .op           (op_reg),
        .pick_found   (pick_found),
        .pick_idx     (pick_idx),
        .exec_latency (latency_reg),
        .busy_vec     (busy_vec),
        .ready_next   (ready_next),
        .captured     (captured)
    );

    assign idx_ext   = 32'(pick_idx);
    assign cap_ext   = 32'(captured);
    assign ready_pad = PAD_W'(ready_next);

    always_comb
    begin
        accepted_next = 1'b0;
        slot_next     = '0;
        full_next     = 1'b0;
        count_next    = '0;
        unique case (op_reg.command)
            rsu_pkg::CMD_ISSUE:
            begin
                accepted_next = pick_found;
                full_next     = !pick_found;
                if (pick_found)
                    slot_next = idx_ext[rsu_pkg::SLOT_W-1:0];
            end
            rsu_pkg::CMD_BCAST:
            begin
                accepted_next = 1'b1;
                count_next    = cap_ext[rsu_pkg::CNT_W-1:0];
            end
            rsu_pkg::CMD_RELEASE:
                accepted_next = int'(op_reg.release_slot) < RS_DEPTH;
            rsu_pkg::CMD_FLUSH:
                accepted_next = 1'b1;
            default:
                accepted_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= op_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (op_valid_reg)
        begin
            accepted_reg <= accepted_next;
            slot_reg     <= slot_next;
            full_reg     <= full_next;
            count_reg    <= count_next;
            mask_reg     <= ready_pad[rsu_pkg::MASK_W-1:0];
        end
    end

    assign done           = done_reg;
    assign accepted       = accepted_reg;
    assign slot           = slot_reg;
    assign full_res       = full_reg;
    assign captured_count = count_reg;
    assign ready_mask     = mask_reg;

endmodule

### rtl/rsu_slot_pick.sv
// Lowest-free-entry finder for the reservation station.
// Depends on nothing but its parameters.

module rsu_slot_pick #(
    parameter int RS_DEPTH = 8,
    parameter int IDX_W    = 3
) (
    input  logic [RS_DEPTH-1:0] busy_vec,
    output logic                found,
    output logic [IDX_W-1:0]    idx
);

    // Scan from the top so the lowest free entry wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = RS_DEPTH - 1; i >= 0; i--)
        begin
            if (!busy_vec[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

### rtl/rsu_entry_array.sv
// Entry storage of the reservation station: flags, tags, operand values.
// Applies one command word per cycle; depends on rsu_pkg.

module rsu_entry_array #(
    parameter int RS_DEPTH = 8,
    parameter int IDX_W    = 3,
    parameter int CAP_W    = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     op_valid,
    input  rsu_pkg::op_t             op,
    input  logic                     pick_found,
    input  logic [IDX_W-1:0]         pick_idx,
    input  logic [rsu_pkg::LAT_W-1:0] exec_latency,
    output logic [RS_DEPTH-1:0]      busy_vec,
    output logic [RS_DEPTH-1:0]      ready_next,
    output logic [CAP_W-1:0]         captured
);

    logic [RS_DEPTH-1:0] busy_reg, busy_next;
    logic [RS_DEPTH-1:0] a_wait_reg, a_wait_next;
    logic [RS_DEPTH-1:0] b_wait_reg, b_wait_next;

    logic [rsu_pkg::OPC_W-1:0] opcode_reg [RS_DEPTH];
    logic [rsu_pkg::ROB_W-1:0] rob_reg    [RS_DEPTH];
    logic [rsu_pkg::TAG_W-1:0] a_tag_reg  [RS_DEPTH];
    logic [rsu_pkg::VAL_W-1:0] a_val_reg  [RS_DEPTH];
    logic [rsu_pkg::TAG_W-1:0] b_tag_reg  [RS_DEPTH];
    logic [rsu_pkg::VAL_W-1:0] b_val_reg  [RS_DEPTH];
    logic [rsu_pkg::LAT_W-1:0] cycles_reg [RS_DEPTH];

    logic [RS_DEPTH-1:0] issue_hit;
    logic [RS_DEPTH-1:0] a_match;
    logic [RS_DEPTH-1:0] b_match;

    always_comb
    begin
        busy_next   = busy_reg;
        a_wait_next = a_wait_reg;
        b_wait_next = b_wait_reg;
        issue_hit   = '0;
        a_match     = '0;
        b_match     = '0;
        for (int i = 0; i < RS_DEPTH; i++)
        begin
            if (op_valid)
            begin
                unique case (op.command)
                    rsu_pkg::CMD_ISSUE:
                    begin
                        if (pick_found && (pick_idx == IDX_W'(i)))
                        begin
                            issue_hit[i]   = 1'b1;
                            busy_next[i]   = 1'b1;
                            a_wait_next[i] = op.src1_waiting;
                            b_wait_next[i] = op.src2_waiting;
                        end
                    end
                    rsu_pkg::CMD_BCAST:
                    begin
                        a_match[i] = busy_reg[i] && a_wait_reg[i]
                                     && (a_tag_reg[i] == op.bcast_tag);
                        b_match[i] = busy_reg[i] && b_wait_reg[i]
                                     && (b_tag_reg[i] == op.bcast_tag);
                        if (a_match[i])
                            a_wait_next[i] = 1'b0;
                        if (b_match[i])
                            b_wait_next[i] = 1'b0;
                    end
                    rsu_pkg::CMD_RELEASE:
                    begin
                        if (int'(op.release_slot) == i)
                        begin
                            busy_next[i]   = 1'b0;
                            a_wait_next[i] = 1'b0;
                            b_wait_next[i] = 1'b0;
                        end
                    end
                    rsu_pkg::CMD_FLUSH:
                    begin
                        busy_next[i]   = 1'b0;
                        a_wait_next[i] = 1'b0;
                        b_wait_next[i] = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        captured = '0;
        for (int i = 0; i < RS_DEPTH; i++)
            captured = captured + CAP_W'(a_match[i]) + CAP_W'(b_match[i]);
    end

    assign ready_next = busy_next & ~a_wait_next & ~b_wait_next;
    assign busy_vec   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            a_wait_reg <= '0;
            b_wait_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            a_wait_reg <= a_wait_next;
            b_wait_reg <= b_wait_next;
        end
    end

    // Payload stores: no reset, only read behind a valid wait flag
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RS_DEPTH; i++)
        begin
            if (issue_hit[i])
            begin
                opcode_reg[i] <= op.opcode;
                rob_reg[i]    <= op.rob_id;
                a_tag_reg[i]  <= op.src1_tag;
                a_val_reg[i]  <= op.src1_waiting ? '0 : op.src1_value;
                b_tag_reg[i]  <= op.src2_tag;
                b_val_reg[i]  <= op.src2_waiting ? '0 : op.src2_value;
                cycles_reg[i] <= exec_latency;
            end
            else
            begin
                if (a_match[i])
                    a_val_reg[i] <= op.bcast_value;
                if (b_match[i])
                    b_val_reg[i] <= op.bcast_value;
            end
        end
    end

endmodule
